// ===== hdl/ert_pkg.sv =====
// shared types, constants and codes for the eased ramp timeline
`default_nettype none

package ert_pkg;

  // fixed point format of the progress value
  localparam int FRAC_BITS = 16;
  localparam int ALPHA_W   = FRAC_BITS + 1;
  localparam logic [ALPHA_W-1:0] ONE_FX  = ALPHA_W'(1) << FRAC_BITS;
  localparam logic [ALPHA_W-1:0] HALF_FX = ALPHA_W'(1) << (FRAC_BITS - 1);

  // field widths
  localparam int DUR_W     = 32;
  localparam int DELTA_W   = 16;
  localparam int MODE_W    = 2;
  localparam int CURVE_W   = 2;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;

  // easing curves
  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
  localparam logic [CURVE_W-1:0] CURVE_IN     = 2'd1;
  localparam logic [CURVE_W-1:0] CURVE_OUT    = 2'd2;
  localparam logic [CURVE_W-1:0] CURVE_INOUT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_CURVE = 1'd1;

  // input request
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DELTA_W-1:0] delta_time;
  } in_item_t;

  // result
  typedef struct packed {
    logic [ALPHA_W-1:0] eased_alpha;
    logic               finished;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/ert_div.sv =====
// iterative restoring divider: floor(num * 2^FRAC_BITS / den) for num <= den
`default_nettype none

module ert_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ert_pkg::DUR_W-1:0]   num,
  input  wire logic [ert_pkg::DUR_W-1:0]   den,
  output logic                             done,
  output logic [ert_pkg::ALPHA_W-1:0]      quo
);
  import ert_pkg::*;

  localparam int CNT_W = $clog2(ALPHA_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ALPHA_W - 1);

  logic [DUR_W:0]   rem;
  logic [DUR_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;
  logic [DUR_W:0]   rem_sub;

  // one quotient bit per cycle
  assign ge      = rem >= {1'b0, dvs};
  assign rem_sub = ge ? (rem - {1'b0, dvs}) : rem;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      quo <= {quo[ALPHA_W-2:0], ge};
      rem <= {rem_sub[DUR_W-1:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ert_ease.sv =====
// quadratic easing: one squaring multiply, then shaping of the result
`default_nettype none

module ert_ease (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ert_pkg::ALPHA_W-1:0]   t,
  input  wire logic [ert_pkg::CURVE_W-1:0]   curve,
  output logic                               done,
  output logic [ert_pkg::ALPHA_W-1:0]        alpha
);
  import ert_pkg::*;

  localparam int PROD_W = 2 * ALPHA_W;

  logic [ALPHA_W-1:0] u;
  logic               use_u;
  logic [ALPHA_W-1:0] opnd;
  logic [PROD_W-1:0]  prod;
  logic [ALPHA_W-1:0] t_q;
  logic [CURVE_W-1:0] curve_q;
  logic               upper_q;
  logic               mul_vld;
  logic [ALPHA_W-1:0] shape;

  // pick t or its complement for squaring
  assign u     = ONE_FX - t;
  assign use_u = (curve == CURVE_OUT) || ((curve == CURVE_INOUT) && (t >= HALF_FX));
  assign opnd  = use_u ? u : t;

  // multiply stage
  always_ff @(posedge clk) begin
    prod    <= PROD_W'(opnd) * PROD_W'(opnd);
    t_q     <= t;
    curve_q <= curve;
    upper_q <= t >= HALF_FX;
  end

  // shape the square per curve
  always_comb begin
    unique case (curve_q)
      CURVE_IN:    shape = prod[2*FRAC_BITS:FRAC_BITS];
      CURVE_OUT:   shape = ONE_FX - prod[2*FRAC_BITS:FRAC_BITS];
      CURVE_INOUT: shape = upper_q ? (ONE_FX - prod[2*FRAC_BITS-1:FRAC_BITS-1])
                                   : prod[2*FRAC_BITS-1:FRAC_BITS-1];
      default:     shape = t_q;
    endcase
  end

  // result stage
  always_ff @(posedge clk) begin
    alpha <= shape;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      mul_vld <= start;
      done    <= mul_vld;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eased_ramp_timeline.sv =====
// eased ramp timeline top level: state, sequencer, divider and easing units
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------
//   in       | input     | in_valid / in_stall | mode, delta_time
//   out      | output    | out_valid/out_stall | eased_alpha, finished
//   cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// a tick request while playing is handled in order: elapsed is moved and clamped, the
// divider runs FRAC_BITS+1 steps, the quotient is handed over, and the easing unit
// multiplies and shapes it; the next request is taken only after the result is taken.
// play, reverse, ignored and stopped tick requests pass the move state and give no result.
// in_stall is high from acceptance until the result is taken, out_stall holds the result.
// rst is synchronous; it clears elapsed and playback, sets duration to one and the curve linear.
`default_nettype none

module eased_ramp_timeline (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ert_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ert_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [ert_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ert_pkg::CFG_W-1:0]       cfg_data
);
  import ert_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOVE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_EASE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [DUR_W-1:0]   duration;
  logic [CURVE_W-1:0] ease_curve;
  logic [DUR_W-1:0]   elapsed;
  logic [DUR_W-1:0]   elapsed_next;
  logic               playing;
  logic               reversing;
  logic               fin;
  logic               fin_next;
  in_item_t           req;

  logic [DUR_W-1:0]   dur_eff;
  logic [DUR_W:0]     fwd_sum;
  logic               rev_neg;
  logic [DUR_W-1:0]   rev_diff;
  logic               hit_hi;
  logic               hit_lo;
  logic               do_tick;

  logic               div_start;
  logic               div_done;
  logic [ALPHA_W-1:0] div_quo;
  logic               ease_done;
  logic [ALPHA_W-1:0] ease_alpha;

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_OUT;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= DUR_W'(1);
      ease_curve <= CURVE_LINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DURATION:   duration   <= cfg_data[DUR_W-1:0];
        REG_EASE_CURVE: ease_curve <= cfg_data[CURVE_W-1:0];
        default:        ;
      endcase
    end
  end

  // move and clamp of elapsed time
  assign dur_eff  = (duration == '0) ? DUR_W'(1) : duration;
  assign fwd_sum  = {1'b0, elapsed} + {{(DUR_W + 1 - DELTA_W){1'b0}}, req.delta_time};
  assign rev_neg  = elapsed < {{(DUR_W - DELTA_W){1'b0}}, req.delta_time};
  assign rev_diff = elapsed - {{(DUR_W - DELTA_W){1'b0}}, req.delta_time};

  always_comb begin
    if (reversing) begin
      hit_hi = !rev_neg && (rev_diff >= dur_eff);
      hit_lo = rev_neg || (rev_diff == '0);
    end else begin
      hit_hi = fwd_sum >= {1'b0, dur_eff};
      hit_lo = fwd_sum == '0;
    end
  end

  always_comb begin
    priority if (hit_hi) begin
      elapsed_next = dur_eff;
      fin_next     = 1'b1;
    end else if (hit_lo) begin
      elapsed_next = '0;
      fin_next     = 1'b1;
    end else begin
      elapsed_next = reversing ? rev_diff : fwd_sum[DUR_W-1:0];
      fin_next     = 1'b0;
    end
  end

  assign do_tick   = (state == S_MOVE) && (req.mode == MODE_TICK) && playing;
  assign div_start = do_tick;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MOVE;
      S_MOVE: state_next = do_tick ? S_DIV : S_IDLE;
      S_DIV:  if (div_done) state_next = S_EASE;
      S_EASE: if (ease_done) state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elapsed   <= '0;
      playing   <= 1'b0;
      reversing <= 1'b0;
      fin       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MOVE) begin
        unique case (req.mode)
          MODE_PLAY: begin
            playing   <= 1'b1;
            reversing <= 1'b0;
          end
          MODE_REVERSE: begin
            playing   <= 1'b1;
            reversing <= 1'b1;
          end
          MODE_TICK: if (playing) begin
            elapsed <= elapsed_next;
            fin     <= fin_next;
            if (fin_next) playing <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ease_done) begin
      out_data.eased_alpha <= ease_alpha;
      out_data.finished    <= fin;
    end
  end

  ert_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (elapsed_next),
    .den   (dur_eff),
    .done  (div_done),
    .quo   (div_quo)
  );

  ert_ease u_ease (
    .clk   (clk),
    .rst   (rst),
    .start (div_done),
    .t     (div_quo),
    .curve (ease_curve),
    .done  (ease_done),
    .alpha (ease_alpha)
  );

endmodule

`default_nettype wire

// ===== hdl/ert_check.sv =====
// port-level checks for the eased ramp timeline, bound to the top level
`default_nettype none

module ert_check (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire ert_pkg::in_item_t               in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire ert_pkg::out_item_t              out_data
);
  import ert_pkg::*;

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second request at once");

  // no new request while a result waits
  a_stall_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // eased value never above one
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.eased_alpha <= ONE_FX)
    else $error("eased value out of range");

endmodule

bind eased_ramp_timeline ert_check u_ert_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
